// ===== sv/dle_char_stuff_framer_macros.svh =====
// Assertion macros used by the framer job queue (dcs_queue).
`ifndef DLE_CHAR_STUFF_FRAMER_MACROS_SVH
`define DLE_CHAR_STUFF_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define DCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/dcs_pkg.sv =====
// Shared types, characters and result-position tables for the DLE framer.
package dcs_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_kind;

    localparam t_byte CH_D = 8'h64;
    localparam t_byte CH_L = 8'h6C;
    localparam t_byte CH_E = 8'h65;
    localparam t_byte CH_T = 8'h74;
    localparam t_byte CH_X = 8'h78;

    localparam t_kind KIND_DATA  = 2'd0;
    localparam t_kind KIND_END   = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    localparam t_byte HDR_SEQ [6] = '{8'h64, 8'h6C, 8'h65, 8'h73, 8'h74, 8'h78};
    localparam t_byte TRL_SEQ [6] = '{8'h64, 8'h6C, 8'h65, 8'h65, 8'h74, 8'h78};

    // A job is a mask over a fixed sequence of result slots, emitted in slot order:
    // header(6), held prefix d/l(2), data byte(1), dle dle(6), error, end,
    // flushed d/l(2), trailer(6).
    localparam int unsigned NUM_POS = 25;
    localparam int unsigned POS_HDR  = 0;
    localparam int unsigned POS_PRE  = 6;
    localparam int unsigned POS_BYTE = 8;
    localparam int unsigned POS_DBL  = 9;
    localparam int unsigned POS_ERR  = 15;
    localparam int unsigned POS_END  = 16;
    localparam int unsigned POS_POST = 17;
    localparam int unsigned POS_TRL  = 19;

    typedef logic [NUM_POS-1:0] t_mask;
    typedef logic [4:0]         t_pos;

    typedef struct packed {
        t_mask mask;
        t_byte data;
    } t_job;

    // header character at hunt position p (0..5)
    function automatic t_byte hdr_char(input logic [2:0] p);
        t_byte c;
        c = (p < 3'd6) ? HDR_SEQ[p] : 8'h00;
        return c;
    endfunction

    // character carried by a result slot
    function automatic t_byte pos_byte(input t_pos p, input t_byte data);
        t_pos  off;
        t_byte c;
        off = '0;
        c   = 8'h00;
        if (p < t_pos'(POS_PRE)) begin
            c = HDR_SEQ[p[2:0]];
        end else if (p < t_pos'(POS_BYTE)) begin
            off = p - t_pos'(POS_PRE);
            c   = TRL_SEQ[off[2:0]];
        end else if (p == t_pos'(POS_BYTE)) begin
            c = data;
        end else if (p < t_pos'(POS_DBL + 3)) begin
            off = p - t_pos'(POS_DBL);
            c   = TRL_SEQ[off[2:0]];
        end else if (p < t_pos'(POS_ERR)) begin
            off = p - t_pos'(POS_DBL + 3);
            c   = TRL_SEQ[off[2:0]];
        end else if (p < t_pos'(POS_POST)) begin
            c = 8'h00;
        end else if (p < t_pos'(POS_TRL)) begin
            off = p - t_pos'(POS_POST);
            c   = TRL_SEQ[off[2:0]];
        end else begin
            off = p - t_pos'(POS_TRL);
            c   = (off < t_pos'(6)) ? TRL_SEQ[off[2:0]] : 8'h00;
        end
        return c;
    endfunction

    // result kind of a slot
    function automatic t_kind pos_kind(input t_pos p);
        t_kind k;
        k = KIND_DATA;
        if (p == t_pos'(POS_ERR)) begin
            k = KIND_ERROR;
        end else if (p == t_pos'(POS_END)) begin
            k = KIND_END;
        end
        return k;
    endfunction

endpackage

// ===== sv/dcs_if.sv =====
// Valid/ready stream interfaces for the framer input and result channels.
interface dle_in_if;
    import dcs_pkg::*;
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface dle_out_if;
    import dcs_pkg::*;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    t_kind out_kind;
    logic  out_last;
    modport source (output valid, out_byte, out_kind, out_last, input ready);
    modport sink   (input valid, out_byte, out_kind, out_last, output ready);
endinterface

// ===== sv/dcs_front.sv =====
// Front end: accepts bytes, tracks framing state, and emits a job for each byte that causes results.
module dcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dle_in_if.sink        i_in,
    input  logic          i_cfg_we,
    input  logic          i_cfg_mode,
    output logic          o_mode,
    input  logic          i_q_full,
    output logic          o_push,
    output dcs_pkg::t_job o_job
);
    import dcs_pkg::*;

    // match progress codes (stuff uses IDLE..DL, destuff inside a frame uses all)
    localparam logic [2:0] PROG_IDLE  = 3'd0;
    localparam logic [2:0] PROG_D     = 3'd1;
    localparam logic [2:0] PROG_DL    = 3'd2;
    localparam logic [2:0] PROG_DLE   = 3'd3;
    localparam logic [2:0] PROG_DLED  = 3'd4;
    localparam logic [2:0] PROG_DLEDL = 3'd5;
    localparam logic [2:0] PROG_DLEE  = 3'd6;
    localparam logic [2:0] PROG_DLEET = 3'd7;
    localparam logic [2:0] HUNT_LAST  = 3'd5;

    logic       r_mode;
    logic       r_open, n_open;
    logic [2:0] r_prog, n_prog;
    logic [2:0] p;
    t_mask      mask;
    t_byte      b;
    logic       hold_d;
    logic       err;
    logic       fire;

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && !i_q_full;
    assign o_mode     = r_mode;

    // classify the byte against the current state
    always_comb begin
        mask   = '0;
        n_open = r_open;
        b      = i_in.in_byte;
        hold_d = (b == CH_D);
        err    = 1'b0;
        p      = r_prog;
        if (!r_mode) begin
            // stuffing
            if (p > PROG_DL) p = PROG_IDLE;
            if (!r_open) begin
                mask[POS_HDR +: 6] = '1;
                p = PROG_IDLE;
            end
            case (p)
                PROG_D: begin
                    if (b == CH_L) begin
                        p = PROG_DL;
                    end else begin
                        mask[POS_PRE]  = 1'b1;
                        mask[POS_BYTE] = !hold_d;
                        p = hold_d ? PROG_D : PROG_IDLE;
                    end
                end
                PROG_DL: begin
                    if (b == CH_E) begin
                        mask[POS_DBL +: 6] = '1;
                        p = PROG_IDLE;
                    end else begin
                        mask[POS_PRE +: 2] = '1;
                        mask[POS_BYTE]     = !hold_d;
                        p = hold_d ? PROG_D : PROG_IDLE;
                    end
                end
                default: begin
                    mask[POS_BYTE] = !hold_d;
                    p = hold_d ? PROG_D : PROG_IDLE;
                end
            endcase
            if (i_in.in_last) begin
                mask[POS_POST]     = (p != PROG_IDLE);
                mask[POS_POST + 1] = (p == PROG_DL);
                mask[POS_TRL +: 6] = '1;
                n_open = 1'b0;
                p = PROG_IDLE;
            end else begin
                n_open = 1'b1;
            end
        end else if (r_open) begin
            // destuffing inside a frame
            case (p)
                PROG_D: begin
                    if (b == CH_L) begin
                        p = PROG_DL;
                    end else begin
                        mask[POS_PRE]  = 1'b1;
                        mask[POS_BYTE] = !hold_d;
                        p = hold_d ? PROG_D : PROG_IDLE;
                    end
                end
                PROG_DL: begin
                    if (b == CH_E) begin
                        p = PROG_DLE;
                    end else begin
                        mask[POS_PRE +: 2] = '1;
                        mask[POS_BYTE]     = !hold_d;
                        p = hold_d ? PROG_D : PROG_IDLE;
                    end
                end
                PROG_DLE: begin
                    if (b == CH_D)      p = PROG_DLED;
                    else if (b == CH_E) p = PROG_DLEE;
                    else                err = 1'b1;
                end
                PROG_DLED: begin
                    if (b == CH_L) p = PROG_DLEDL;
                    else           err = 1'b1;
                end
                PROG_DLEDL: begin
                    if (b == CH_E) begin
                        mask[POS_DBL +: 3] = '1;
                        p = PROG_IDLE;
                    end else begin
                        err = 1'b1;
                    end
                end
                PROG_DLEE: begin
                    if (b == CH_T) p = PROG_DLEET;
                    else           err = 1'b1;
                end
                PROG_DLEET: begin
                    if (b == CH_X) begin
                        mask[POS_END] = 1'b1;
                        n_open = 1'b0;
                        p = PROG_IDLE;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: begin
                    mask[POS_BYTE] = !hold_d;
                    p = hold_d ? PROG_D : PROG_IDLE;
                end
            endcase
            if (err) begin
                mask[POS_ERR] = 1'b1;
                n_open = 1'b0;
                p = hold_d ? PROG_D : PROG_IDLE;
            end
        end else begin
            // hunting for the header
            if (p > HUNT_LAST) p = PROG_IDLE;
            if (b == hdr_char(p)) begin
                if (p == HUNT_LAST) begin
                    n_open = 1'b1;
                    p = PROG_IDLE;
                end else begin
                    p = p + 3'd1;
                end
            end else begin
                mask[POS_ERR] = 1'b1;
                p = hold_d ? PROG_D : PROG_IDLE;
            end
        end
        n_prog = p;
    end

    assign o_push     = fire && (mask != '0);
    assign o_job.mask = mask;
    assign o_job.data = b;

    // mode and framing state; a mode write restarts framing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_open <= 1'b0;
            r_prog <= PROG_IDLE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
            r_open <= 1'b0;
            r_prog <= PROG_IDLE;
        end else if (fire) begin
            r_open <= n_open;
            r_prog <= n_prog;
        end
    end

endmodule

// ===== sv/dcs_queue.sv =====
// Small job queue between the classifier and the result expander.
`include "dle_char_stuff_framer_macros.svh"
module dcs_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dcs_pkg::t_job o_job
);
    import dcs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    `DCS_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `DCS_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `DCS_ASSERT_NEXT(a_cnt_grow, i_clk, i_rst_n, i_push && !i_pop, r_cnt == CW'($past(r_cnt) + 1'b1), "fill count did not advance")

endmodule

// ===== sv/dcs_back.sv =====
// Back end: expands one job into its result transactions, one per cycle while o_out is ready.
module dcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dcs_pkg::t_job i_q_job,
    output logic          o_pop,
    dle_out_if.source     o_out
);
    import dcs_pkg::*;

    t_mask r_rem, n_rem;
    t_byte r_data;
    t_pos  pos;
    t_mask rem_next;
    logic  last;
    logic  fire;
    logic  load;

    // lowest pending slot is the current result
    always_comb begin
        pos = '0;
        for (int k = NUM_POS - 1; k >= 0; k--) begin
            if (r_rem[k]) pos = t_pos'(k);
        end
    end

    assign rem_next = r_rem & (r_rem - 1'b1);
    assign last     = (rem_next == '0);
    assign fire     = o_out.valid && o_out.ready;
    assign load     = (r_rem == '0) || (fire && last);
    assign o_pop    = load && i_q_valid;

    assign o_out.valid    = (r_rem != '0);
    assign o_out.out_byte = pos_byte(pos, r_data);
    assign o_out.out_kind = pos_kind(pos);
    assign o_out.out_last = last;

    // next pending set
    always_comb begin
        if (load)      n_rem = i_q_valid ? i_q_job.mask : '0;
        else if (fire) n_rem = rem_next;
        else           n_rem = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rem <= '0;
        else          r_rem <= n_rem;
    end

    // data byte of the job in service
    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_q_job.data;
    end

endmodule

// ===== sv/dle_char_stuff_framer.sv =====
// Top level of the DLE/STX/ETX character-stuffing framer and deframer.
// Bytes enter on i_in at up to one per cycle; each accepted byte is classified in
// the same cycle and, if it causes results, queued as a job (QUEUE_DEPTH entries)
// for the expander, which sends results on o_out at one per cycle while o_out is
// ready. A job gives 1 to 13 results (header, doubled DLE and trailer bursts), all
// sent before the next job loads, so sustained input rate is one byte per cycle
// while the average expansion stays at or below one result per byte, and the
// input stalls only when the job queue fills. Bytes that give no result (held
// partial escapes, header bytes while hunting) never occupy the expander.
// Register 0 at byte address 0, bit 0: direction_mode (0 stuff, 1 destuff);
// writing it restarts framing and must happen while the block is idle.
module dle_char_stuff_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dle_in_if.sink      i_in,
    dle_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dcs_pkg::*;

    logic cfg_we;
    logic mode;
    logic push, pop, q_full, q_valid;
    t_job push_job, head_job;

    // register port: one register, any write with address bit 2 low hits it
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, mode};

    dcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (cfg_we),
        .i_cfg_mode (pwdata[0]),
        .o_mode     (mode),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    dcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    dcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== sim/dle_char_stuff_framer_tb.sv =====
// Self-checking testbench for the DLE/STX/ETX character-stuffing framer and deframer.
`timescale 1ns / 100ps

module dle_char_stuff_framer_tb;
    import dcs_pkg::*;

    localparam logic [2:0] REG_MODE_ADDR = 3'd0;
    localparam logic       MODE_STUFF    = 1'b0;
    localparam logic       MODE_DESTUFF  = 1'b1;
    localparam t_byte      CH_S          = 8'h73;
    localparam t_byte      CH_Q          = 8'h71;

    // destuff progress inside an open frame
    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_D     = 4'd1;
    localparam logic [3:0] P_DL    = 4'd2;
    localparam logic [3:0] P_DLE   = 4'd3;
    localparam logic [3:0] P_DLED  = 4'd4;
    localparam logic [3:0] P_DLEDL = 4'd5;
    localparam logic [3:0] P_DLEE  = 4'd6;
    localparam logic [3:0] P_DLEET = 4'd7;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 61;

    typedef struct packed {
        t_byte data;
        t_kind kind;
        logic  last;
    } t_char_result;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_char_in;

    // Framer predictor and result checker
    class frame_scoreboard;
        logic         destuff;
        logic         open;
        logic [3:0]   prog;
        t_char_result frame_chars_q[$];
        t_char_result burst[$];
        int errors, n_stuffed, n_destuffed, n_checked, n_ends, n_errs;

        function new();
            destuff = MODE_STUFF;
            open    = 1'b0;
            prog    = P_IDLE;
        endfunction

        function void set_mode(logic m);
            destuff = m;
            open    = 1'b0;
            prog    = P_IDLE;
        endfunction

        function int pending();
            return frame_chars_q.size();
        endfunction

        function void put(t_byte b, t_kind k);
            t_char_result r;
            r.data = b;
            r.kind = k;
            r.last = 1'b0;
            burst.push_back(r);
        endfunction

        function void put_dle();
            for (int i = 0; i < 3; i++) put(TRL_SEQ[i], KIND_DATA);
        endfunction

        // plain byte from idle: a 'd' is held, anything else passes
        function void plain_or_hold(t_byte b);
            if (b == CH_D) begin
                prog = P_D;
            end else begin
                put(b, KIND_DATA);
                prog = P_IDLE;
            end
        endfunction

        function void framing_error(t_byte b);
            put(8'h00, KIND_ERROR);
            open = 1'b0;
            prog = (b == CH_D) ? P_D : P_IDLE;
        endfunction

        function void stuff_char(t_byte b, logic last);
            if (prog > P_DL) prog = P_IDLE;
            if (!open) begin
                for (int i = 0; i < 6; i++) put(HDR_SEQ[i], KIND_DATA);
                open = 1'b1;
                prog = P_IDLE;
            end
            case (prog)
                P_D: begin
                    if (b == CH_L) begin
                        prog = P_DL;
                    end else begin
                        put(CH_D, KIND_DATA);
                        plain_or_hold(b);
                    end
                end
                P_DL: begin
                    if (b == CH_E) begin
                        put_dle();
                        put_dle();
                        prog = P_IDLE;
                    end else begin
                        put(CH_D, KIND_DATA);
                        put(CH_L, KIND_DATA);
                        plain_or_hold(b);
                    end
                end
                default: plain_or_hold(b);
            endcase
            // end of frame: flush held bytes, then trailer
            if (last) begin
                if (prog >= P_D) put(CH_D, KIND_DATA);
                if (prog >= P_DL) put(CH_L, KIND_DATA);
                for (int i = 0; i < 6; i++) put(TRL_SEQ[i], KIND_DATA);
                open = 1'b0;
                prog = P_IDLE;
            end
        endfunction

        function void hunt_char(t_byte b);
            if (prog > 4'd5) prog = 4'd0;
            if (b == HDR_SEQ[prog[2:0]]) begin
                prog = prog + 4'd1;
                if (prog == 4'd6) begin
                    open = 1'b1;
                    prog = P_IDLE;
                end
            end else begin
                put(8'h00, KIND_ERROR);
                prog = (b == CH_D) ? P_D : P_IDLE;
            end
        endfunction

        function void destuff_char(t_byte b);
            case (prog)
                P_D: begin
                    if (b == CH_L) begin
                        prog = P_DL;
                    end else begin
                        put(CH_D, KIND_DATA);
                        plain_or_hold(b);
                    end
                end
                P_DL: begin
                    if (b == CH_E) begin
                        prog = P_DLE;
                    end else begin
                        put(CH_D, KIND_DATA);
                        put(CH_L, KIND_DATA);
                        plain_or_hold(b);
                    end
                end
                P_DLE: begin
                    if (b == CH_D) prog = P_DLED;
                    else if (b == CH_E) prog = P_DLEE;
                    else framing_error(b);
                end
                P_DLED: begin
                    if (b == CH_L) prog = P_DLEDL;
                    else framing_error(b);
                end
                P_DLEDL: begin
                    if (b == CH_E) begin
                        put_dle();
                        prog = P_IDLE;
                    end else begin
                        framing_error(b);
                    end
                end
                P_DLEE: begin
                    if (b == CH_T) prog = P_DLEET;
                    else framing_error(b);
                end
                P_DLEET: begin
                    if (b == CH_X) begin
                        put(8'h00, KIND_END);
                        open = 1'b0;
                        prog = P_IDLE;
                    end else begin
                        framing_error(b);
                    end
                end
                default: plain_or_hold(b);
            endcase
        endfunction

        // accepted input transaction: queue the characters it causes
        function void note_input(t_byte b, logic last);
            burst.delete();
            if (destuff == MODE_STUFF) begin
                n_stuffed++;
                stuff_char(b, last);
            end else begin
                n_destuffed++;
                if (open) destuff_char(b);
                else hunt_char(b);
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) frame_chars_q.push_back(burst[i]);
        endfunction

        // accepted output transaction: compare with the oldest expectation
        function void check_result(t_byte b, t_kind k, logic last);
            t_char_result exp_r;
            if (frame_chars_q.size() == 0) begin
                $error("unexpected result: out_byte %02h out_kind %0d out_last %0b", b, k, last);
                errors++;
                return;
            end
            exp_r = frame_chars_q.pop_front();
            n_checked++;
            if (b !== exp_r.data) begin
                $error("out_byte: expected %02h, got %02h", exp_r.data, b);
                errors++;
            end
            if (k !== exp_r.kind) begin
                $error("out_kind: expected %0d, got %0d", exp_r.kind, k);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("out_last: expected %0b, got %0b", exp_r.last, last);
                errors++;
            end
            if (exp_r.kind == KIND_END) n_ends++;
            if (exp_r.kind == KIND_ERROR) n_errs++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dle_in_if  in_if ();
    dle_out_if out_if ();

    dle_char_stuff_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_scoreboard sb = new();

    int       tx_idle_pct;
    int       rx_idle_pct;
    int       hold_req_cnt;
    int       hold_seen;
    int       hold_left;
    int       items_sent;
    logic     cur_mode;
    t_char_in tx_q[$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("dle_char_stuff_framer_tb failed");
        $finish;
    end

    // monitor: inputs are noted before results at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_input(in_if.in_byte, in_if.in_last);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.out_byte, out_if.out_kind, out_if.out_last);
        end
    end

    // receiver ready: random stalls, plus a long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        hold_seen    = 0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_req_cnt) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function t_byte pick_byte();
        t_byte b;
        case ($urandom_range(11))
            0, 1:    b = CH_D;
            2:       b = CH_L;
            3:       b = CH_E;
            4:       b = CH_T;
            5:       b = CH_X;
            6:       b = CH_S;
            7:       b = 8'h00;
            8:       b = 8'hFF;
            default: b = t_byte'($urandom_range(255));
        endcase
        return b;
    endfunction

    // in_last only matters when stuffing; randomize it otherwise
    function void add_byte(t_byte b);
        t_char_in c;
        c.data = b;
        c.last = (cur_mode == MODE_DESTUFF) ? 1'($urandom_range(1)) : 1'b0;
        tx_q.push_back(c);
    endfunction

    function void add_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(t_byte'(s[i]));
    endfunction

    // one stuff-mode frame, sometimes left open so the next one continues it
    function void build_stuff_frame();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(4) == 0) add_str("dle");
            else add_byte(pick_byte());
        end
        if ($urandom_range(9) != 0) tx_q[tx_q.size() - 1].last = 1'b1;
    endfunction

    // mostly well-formed received frames, some corrupted, some noise
    function void build_destuff_frame();
        int r;
        int ntok;
        int pos;
        r = $urandom_range(9);
        if (r == 0) begin
            ntok = $urandom_range(1, 6);
            for (int i = 0; i < ntok; i++) add_byte(pick_byte());
        end else begin
            add_str("dlestx");
            ntok = $urandom_range(0, 6);
            for (int i = 0; i < ntok; i++) begin
                if ($urandom_range(3) == 0) add_str("dledle");
                else add_byte(pick_byte());
            end
            add_str("dleetx");
            if (r == 1) begin
                pos = $urandom_range(0, tx_q.size() - 1);
                tx_q[pos].data = pick_byte();
            end
        end
    endfunction

    // offer one byte, with random sender gaps; returns at the accepting edge
    task automatic send_byte(input t_char_in c);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= c.data;
        in_if.in_last <= c.last;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_queued();
        while (tx_q.size() > 0) send_byte(tx_q.pop_front());
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
    endtask

    // mode change once the block is idle, with read-back
    task automatic set_mode(input logic m);
        logic [31:0] rd;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_access(1'b1, REG_MODE_ADDR, 32'(m), rd);
        sb.set_mode(m);
        cur_mode = m;
        apb_access(1'b0, REG_MODE_ADDR, 32'h0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(m)) begin
            $error("direction_mode: expected %0d, got %0h", m, rd);
            sb.errors++;
        end
    endtask

    task automatic run_random(input int n, input bit hold_mid, input bit pause_mid);
        int  start;
        bit  mid_done;
        start    = items_sent;
        mid_done = 0;
        while (items_sent - start < n) begin
            if (cur_mode == MODE_DESTUFF) build_destuff_frame();
            else build_stuff_frame();
            send_queued();
            if (!mid_done && items_sent - start >= n / 2) begin
                mid_done = 1;
                if (hold_mid) hold_req_cnt <= hold_req_cnt + 1;
                if (pause_mid) drain_results();
            end
        end
        // leave a partial escape held so the next mode write drops it
        if (cur_mode == MODE_STUFF) begin
            add_str("dl");
            send_queued();
        end
    endtask

    // stimulus
    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = REG_MODE_ADDR;
        pwdata        = 32'h0;
        tx_idle_pct   = 6;
        rx_idle_pct   = 72;
        hold_req_cnt  = 0;
        items_sent    = 0;
        cur_mode      = MODE_STUFF;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed stuffing: lone d with last, extremes, doubled dle
        set_mode(MODE_STUFF);
        tx_q.push_back('{CH_D, 1'b1});
        tx_q.push_back('{8'hFF, 1'b0});
        tx_q.push_back('{CH_D, 1'b0});
        tx_q.push_back('{CH_L, 1'b0});
        tx_q.push_back('{CH_E, 1'b0});
        tx_q.push_back('{8'h00, 1'b1});
        send_queued();

        // directed destuffing: header, partial escape, dledle, bad escape, bad header
        set_mode(MODE_DESTUFF);
        add_str("dlestx");
        add_str("dldledle");
        add_str("dlel");
        add_byte(CH_Q);
        send_queued();

        // random phases: sender-light, receiver-light, then no random idling, with a receiver hold-off and a drain
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct <= (p == 0) ? 6 : ((p == 1) ? 72 : 0);
            rx_idle_pct <= (p == 0) ? 72 : ((p == 1) ? 6 : 0);
            set_mode(MODE_STUFF);
            run_random(PHASE_ITEMS, p == 2, 1'b0);
            set_mode(MODE_DESTUFF);
            run_random(PHASE_ITEMS, 1'b0, p == 2);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d stuffed and %0d destuffed input bytes, %0d results checked.",
                 sb.n_stuffed, sb.n_destuffed, sb.n_checked);
        $display("Destuff side saw %0d frame ends and %0d framing errors; %0d mismatches.",
                 sb.n_ends, sb.n_errs, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("dle_char_stuff_framer_tb passed");
        end else begin
            $display("dle_char_stuff_framer_tb failed");
        end
        $finish;
    end

endmodule

// ===== dle_char_stuff_framer.f =====
+incdir+sv
sv/dcs_pkg.sv
sv/dcs_if.sv
sv/dcs_front.sv
sv/dcs_queue.sv
sv/dcs_back.sv
sv/dle_char_stuff_framer.sv
sim/dle_char_stuff_framer_tb.sv
